>>> rtl/rmsac_pkg.sv
// ----------------------------------------------------------------------------
// rmsac_pkg: shared types and constants for the RMS admission control unit
// Transaction structs, fixed widths, saturation limits and the Liu-Layland
// bound ROM, built at elaboration from a truncating Q30 root search.
// ----------------------------------------------------------------------------
package rmsac_pkg;

  localparam int PERIOD_W    = 20;
  localparam int COMP_W      = 20;
  localparam int PRIO_W      = 16;
  localparam int TOTAL_W     = 18;
  localparam int UTIL_W      = 18;
  localparam int SUM_W       = 17;
  localparam int COUNT_W     = 7;
  localparam int SLACK_W     = 16;
  localparam int BOUND_W     = 17;
  localparam int ROM_DEPTH   = 128;

  // comp << 16 gives a 36-bit dividend; quotient kept to 18 bits plus overflow
  localparam int UTIL_DVD_W  = COMP_W + 16;
  localparam int UTIL_QUO_W  = UTIL_W;
  localparam int PRIO_DVD_W  = PRIO_W;
  localparam int PRIO_QUO_W  = PRIO_W;

  localparam int MAX_TASKS_DEF = 64;

  localparam logic [UTIL_W-1:0]   UTIL_SAT  = 18'h20000;
  localparam logic [PRIO_W-1:0]   PRIO_MAX  = 16'hFFFF;
  localparam logic [PRIO_W-1:0]   PRIO_MIN  = 16'd1;
  localparam logic [PERIOD_W-1:0] PRIO_CAP  = 20'd65535;
  localparam logic [TOTAL_W-1:0]  TOTAL_SAT = 18'h3FFFF;

  typedef struct packed {
    logic [PERIOD_W-1:0] task_period;
    logic [COMP_W-1:0]   task_comp;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic [PRIO_W-1:0]   task_priority;
    logic [TOTAL_W-1:0]  total_util_q16;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  typedef logic [ROM_DEPTH-1:0][BOUND_W-1:0] bound_rom_t;

  // (1 + x)^k stays at or below 2 in truncating Q30 arithmetic
  function automatic logic root_fits(logic [63:0] x, int k);
    logic [63:0] base;
    logic [63:0] acc;
    logic        fits;
    base = 64'h4000_0000 + x;
    acc  = 64'h4000_0000;
    fits = 1'b1;
    for (int i = 0; i < k; i++) begin
      if (fits) begin
        acc = (acc * base) >> 30;
        if (acc > 64'h8000_0000) fits = 1'b0;
      end
    end
    return fits;
  endfunction

  function automatic logic [BOUND_W-1:0] bound_entry(int k);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] prod;
    lo = 64'd0;
    hi = 64'h4000_0001;
    while (hi - lo > 64'd1) begin
      mid = (lo + hi) >> 1;
      if (root_fits(mid, k)) lo = mid;
      else hi = mid;
    end
    prod = (64'(k) * lo) >> 14;
    return prod[BOUND_W-1:0];
  endfunction

  function automatic bound_rom_t build_bound_rom();
    bound_rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = bound_entry((i == 0) ? 1 : i);
    end
    return rom;
  endfunction

  localparam bound_rom_t BOUND_ROM = build_bound_rom();

endpackage

>>> rtl/rmsac_divider.sv
// ----------------------------------------------------------------------------
// rmsac_divider: bit-serial restoring divider
// Shifts one dividend bit per cycle into the partial remainder and one
// quotient bit out; quotient bits pushed past the top set a sticky overflow.
// ----------------------------------------------------------------------------
module rmsac_divider
  import rmsac_pkg::*;
#(
  parameter int DIVIDEND_W = UTIL_DVD_W,
  parameter int QUO_W      = UTIL_QUO_W,
  parameter int DIVISOR_W  = PERIOD_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [QUO_W-1:0]      quotient,
  output div_stat_t             status
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  assign trial = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      // one quotient bit per cycle
      rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      ovf_nxt = ovf_r | quo_r[QUO_W-1];
      dvd_nxt = {dvd_r[DIVIDEND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign quotient    = quo_r;
  assign status.done = done_r;
  assign status.ovf  = ovf_r;

endmodule

>>> rtl/rms_admission_control_unit.sv
// ----------------------------------------------------------------------------
// rms_admission_control_unit: rate-monotonic admission test
// Divides comp by period in Q16 and 65535 by period bit-serially, adds the
// admitted utilization and slack, and checks the sum against the
// Liu-Layland bound for the next task count.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_stall   | in_data  (task_period, task_comp)
//  out      | out_valid / out_stall | out_data (accepted, priority, total)
//  cfg      | cfg_wr_en             | cfg_wr_data (slack_q16)
//
//  A request passes through the utilization divider (one bit of the 36-bit
//  dividend per cycle), the quotient hand-over, the sum and the bound check.
//  A zero period skips the divider.
//  Reset clears the utilization sum, task count, slack and both handshakes.
//  A result held by out_stall blocks the bound check; input is taken only
//  while no request is in progress.
// ----------------------------------------------------------------------------
module rms_admission_control_unit
  import rmsac_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [SLACK_W-1:0] cfg_wr_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_SUM    = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [SLACK_W-1:0]  slack_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [UTIL_W-1:0]   util_r;
  logic [PRIO_W-1:0]   prio_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r;

  logic                in_accept;
  logic                div_start;
  logic [UTIL_QUO_W-1:0] util_quo;
  logic [PRIO_QUO_W-1:0] prio_quo;
  div_stat_t           util_stat;
  div_stat_t           prio_stat;
  logic [UTIL_W-1:0]   util_sat;
  logic [TOTAL_W:0]    total_raw;
  logic [COUNT_W-1:0]  k_idx;
  logic                ok;
  logic                emit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign div_start = in_accept && (in_data.task_period != '0);

  rmsac_divider #(
    .DIVIDEND_W (UTIL_DVD_W),
    .QUO_W      (UTIL_QUO_W),
    .DIVISOR_W  (PERIOD_W)
  ) u_util_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({in_data.task_comp, 16'h0000}),
    .divisor  (in_data.task_period),
    .quotient (util_quo),
    .status   (util_stat)
  );

  rmsac_divider #(
    .DIVIDEND_W (PRIO_DVD_W),
    .QUO_W      (PRIO_QUO_W),
    .DIVISOR_W  (PERIOD_W)
  ) u_prio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PRIO_MAX),
    .divisor  (in_data.task_period),
    .quotient (prio_quo),
    .status   (prio_stat)
  );

  // saturate utilization at 2.0
  assign util_sat = (util_stat.ovf || (util_quo[UTIL_W-1] && util_quo[UTIL_W-2:0] != '0))
                    ? UTIL_SAT : util_quo;

  assign total_raw = {2'b00, sum_r} + {1'b0, util_r} + {3'b000, slack_r};
  assign k_idx     = count_r + COUNT_W'(1);
  assign ok        = (period_r != '0) && (count_r < COUNT_W'(MAX_TASKS)) &&
                     ({1'b0, total_r} < BOUND_ROM[k_idx]);
  assign emit      = (state_r == ST_DECIDE) && !(out_valid_r && out_stall);

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = div_start ? ST_DIV : ST_SUM;
      end
      ST_DIV: begin
        if (util_stat.done) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (ok) begin
            sum_nxt   = sum_r + util_r[SUM_W-1:0];
            count_nxt = count_r + COUNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slack_r     <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) slack_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      period_r <= in_data.task_period;
      util_r   <= UTIL_SAT;
    end else if ((state_r == ST_DIV) && util_stat.done) begin
      util_r <= util_sat;
    end
    if (prio_stat.done) begin
      if (period_r >= PRIO_CAP) prio_r <= PRIO_MIN;
      else if (prio_stat.ovf) prio_r <= PRIO_MAX;
      else prio_r <= prio_quo;
    end
    if (state_r == ST_SUM) begin
      total_r <= total_raw[TOTAL_W] ? TOTAL_SAT : total_raw[TOTAL_W-1:0];
    end
    if (emit) begin
      out_r.accepted       <= ok;
      out_r.task_priority  <= ok ? prio_r : '0;
      out_r.total_util_q16 <= total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: admission test for rms_admission_control_unit
// Offers periodic task requests and predicts each untyped verdict (accepted
// flag, rate-monotonic priority, tested utilization) from a local copy of
// the admitted utilization, task count and slack. Directed rows come first,
// then random phases with different slack settings and idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import rmsac_pkg::*;

  localparam int          MAX_TASKS       = MAX_TASKS_DEF;
  localparam int unsigned UTIL_CAP        = 131072;
  localparam int unsigned TESTED_CAP      = 262143;
  localparam bit [63:0]   Q30_ONE         = 64'h4000_0000;
  localparam int          DRAIN_CYCLES    = 60;
  localparam int          PHASES          = 5;
  localparam int          ITEMS_PER_PHASE = 110;
  localparam int          SEND_IDLE [PHASES] = '{0, 61, 0, 21, 0};
  localparam int          RECV_STALL[PHASES] = '{0, 0, 61, 21, 0};

  typedef struct packed {
    bit [19:0] period;
    bit [19:0] comp;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 16;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{20'd0,       20'd0,       1'b1, '{1'b0, 16'd0,     18'd131072}},
    '{20'd0,       20'hFFFFF,   1'b1, '{1'b0, 16'd0,     18'd131072}},
    '{20'd1,       20'hFFFFF,   1'b1, '{1'b0, 16'd0,     18'd131072}},
    '{20'hFFFFF,   20'hFFFFF,   1'b1, '{1'b0, 16'd0,     18'd65536}},
    '{20'd1,       20'd0,       1'b1, '{1'b1, 16'd65535, 18'd0}},
    '{20'd2,       20'd0,       1'b1, '{1'b1, 16'd32767, 18'd0}},
    '{20'd65535,   20'd0,       1'b1, '{1'b1, 16'd1,     18'd0}},
    '{20'd65536,   20'd0,       1'b1, '{1'b1, 16'd1,     18'd0}},
    '{20'hFFFFF,   20'd1,       1'b1, '{1'b1, 16'd1,     18'd0}},
    '{20'd65534,   20'd0,       1'b1, '{1'b1, 16'd1,     18'd0}},
    '{20'd3,       20'd1,       1'b0, '{1'b0, 16'd0,     18'd0}},
    '{20'd100,     20'd7,       1'b0, '{1'b0, 16'd0,     18'd0}},
    '{20'd65536,   20'd40000,   1'b0, '{1'b0, 16'd0,     18'd0}},
    '{20'd7,       20'd8,       1'b0, '{1'b0, 16'd0,     18'd0}},
    '{20'hAAAAA,   20'h55555,   1'b0, '{1'b0, 16'd0,     18'd0}},
    '{20'h55555,   20'hAAAAA,   1'b0, '{1'b0, 16'd0,     18'd0}}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_wr_en;
  logic [SLACK_W-1:0]  cfg_wr_data;

  // local copy of the admission state
  int unsigned llb_q16 [1:MAX_TASKS];
  int unsigned util_sum;
  int unsigned task_count;
  int unsigned slack_setting;

  out_item_t   pending_verdicts [$];
  out_item_t   want;
  int          send_idle_pct;
  int          stall_pct;
  int unsigned requests_sent;
  int unsigned tasks_admitted;
  int unsigned verdicts_checked;
  int unsigned mismatches;

  rms_admission_control_unit #(
    .MAX_TASKS (MAX_TASKS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // (1 + x)^k in truncating Q30 steps never exceeds 2
  function automatic bit root_within_two(bit [63:0] x, int k);
    bit [63:0] acc;
    acc = Q30_ONE;
    for (int i = 0; i < k; i++) begin
      acc = (acc * (Q30_ONE + x)) >> 30;
      if (acc > 2 * Q30_ONE) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Liu-Layland bound k(2^(1/k)-1) in Q16
  function automatic int unsigned llb_entry(int k);
    bit [63:0] lo;
    bit [63:0] hi;
    bit [63:0] mid;
    bit [63:0] scaled;
    lo = '0;
    hi = Q30_ONE + 64'd1;
    while (hi - lo > 64'd1) begin
      mid = (lo + hi) >> 1;
      if (root_within_two(mid, k)) lo = mid;
      else hi = mid;
    end
    scaled = (64'(k) * lo) >> 14;
    return 32'(scaled);
  endfunction

  // verdict for one request; advances the admission state on acceptance
  function automatic out_item_t admit_task(in_item_t req);
    out_item_t   verdict;
    bit [35:0]   ratio;
    int unsigned share;
    int unsigned tested;
    bit          ok;
    if (req.task_period == '0) begin
      share = UTIL_CAP;
    end else begin
      ratio = {req.task_comp, 16'h0} / 36'(req.task_period);
      share = (ratio > 36'(UTIL_CAP)) ? UTIL_CAP : 32'(ratio);
    end
    tested = util_sum + share + slack_setting;
    if (tested > TESTED_CAP) tested = TESTED_CAP;
    ok = (req.task_period != '0) && (task_count < MAX_TASKS);
    if (ok) ok = tested < llb_q16[task_count + 1];
    verdict.accepted       = ok;
    verdict.task_priority  = '0;
    verdict.total_util_q16 = 18'(tested);
    if (ok) begin
      util_sum   = (util_sum + share) & 32'h1FFFF;
      task_count = task_count + 1;
      tasks_admitted++;
      verdict.task_priority = (req.task_period >= 20'd65535) ? 16'd1
                              : 16'(20'd65535 / req.task_period);
    end
    return verdict;
  endfunction

  function automatic in_item_t draw_request();
    in_item_t    req;
    int unsigned sel;
    int unsigned k;
    int          gap;
    sel = $urandom_range(99);
    k = (task_count < MAX_TASKS) ? task_count + 1 : MAX_TASKS;
    if (sel < 50) begin
      // light task, comp at most period / 256
      req.task_period = 20'($urandom_range(20'hFFFFF, 256));
      req.task_comp   = 20'($urandom_range(32'(req.task_period >> 8), 0));
    end else if (sel < 65) begin
      // probe the bound edge; period 2^16 makes utilization equal comp
      gap = int'(llb_q16[k]) - int'(util_sum) - int'(slack_setting);
      req.task_period = 20'd65536;
      if (gap < 1)
        req.task_comp = 20'($urandom_range(3));
      else if (task_count == MAX_TASKS - 1 && $urandom_range(1) == 1)
        req.task_comp = 20'(gap - 1);
      else
        req.task_comp = 20'(gap + int'($urandom_range(2)));
    end else if (sel < 70) begin
      req.task_period = '0;
      req.task_comp   = 20'($urandom);
    end else if (sel < 80) begin
      req.task_period = 20'($urandom_range(15));
      req.task_comp   = 20'($urandom);
    end else begin
      req.task_period = 20'($urandom);
      req.task_comp   = 20'($urandom);
    end
    return req;
  endfunction

  task automatic offer_request(input in_item_t req, input bit typed,
                               input out_item_t typed_want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = admit_task(req);
    pending_verdicts.push_back(typed ? typed_want : predicted);
    requests_sent++;
  endtask

  // drop valid, drain all verdicts, then let the unit go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_slack(input bit [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    slack_setting = value;
  endtask

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected transaction %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (out_data.accepted !== want.accepted) begin
          $display("%0t: accepted expected %0d actual %0d", $time,
                   want.accepted, out_data.accepted);
          mismatches++;
        end
        if (out_data.task_priority !== want.task_priority) begin
          $display("%0t: task_priority expected %0d actual %0d", $time,
                   want.task_priority, out_data.task_priority);
          mismatches++;
        end
        if (out_data.total_util_q16 !== want.total_util_q16) begin
          $display("%0t: total_util_q16 expected %0d actual %0d", $time,
                   want.total_util_q16, out_data.total_util_q16);
          mismatches++;
        end
      end
    end
  end

  initial begin
    in_item_t req;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    util_sum         = 0;
    task_count       = 0;
    slack_setting    = 0;
    requests_sent    = 0;
    tasks_admitted   = 0;
    verdicts_checked = 0;
    mismatches       = 0;
    for (int k = 1; k <= MAX_TASKS; k++) llb_q16[k] = llb_entry(k);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      req.task_period = PLAN[r].period;
      req.task_comp   = PLAN[r].comp;
      offer_request(req, PLAN[r].typed, PLAN[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0, 3:    write_slack(16'd0);
        1:       write_slack(16'hFFFF);
        2:       write_slack(16'($urandom_range(2000)));
        default: write_slack(16'($urandom));
      endcase
      send_idle_pct = SEND_IDLE[ph];
      stall_pct     = RECV_STALL[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req = draw_request();
        offer_request(req, 1'b0, '0);
      end
    end

    settle();
    $display("tb: %0d requests over %0d slack phases, %0d tasks admitted",
             requests_sent, PHASES, tasks_admitted);
    $display("tb: %0d verdicts compared, %0d mismatches", verdicts_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
